// File: hw/rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared constants, types and helpers of the pixel pair combiner.
// ----------------------------------------------------------------------------
package ppc_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int PIXEL_WIDTH = 32;
   localparam int COEF_WIDTH  = 32;

   // Operation codes.
   localparam logic [2:0] OP_SUM      = 3'd0;
   localparam logic [2:0] OP_SUM_ZERO = 3'd1;
   localparam logic [2:0] OP_MEAN     = 3'd2;
   localparam logic [2:0] OP_MUL      = 3'd3;
   localparam logic [2:0] OP_DIV      = 3'd4;

   // Result status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_BLANK = 2'd1;
   localparam logic [1:0] STAT_DIVZ  = 2'd2;
   localparam logic [1:0] STAT_SAT   = 2'd3;

   // Register indexes.
   localparam logic [1:0] REG_OPERATION = 2'd0;
   localparam logic [1:0] REG_COEF_A1   = 2'd1;
   localparam logic [1:0] REG_COEF_A2   = 2'd2;
   localparam logic [1:0] REG_COEF_A3   = 2'd3;

   // Divider: 64 quotient bits, four per stage.
   localparam int DIV_BITS       = 64;
   localparam int DIV_PER_STAGE  = 4;
   localparam int DIV_STAGES     = DIV_BITS / DIV_PER_STAGE;
   localparam int PIPE_DEPTH     = 3 + DIV_STAGES + 2;
   localparam int OCC_WIDTH      = $clog2(PIPE_DEPTH + 1);

   typedef struct packed {
      logic [2:0]        operation;
      logic signed [31:0] a1;
      logic signed [31:0] a2;
      logic signed [31:0] a3;
   } cfg_type;

   typedef struct packed {
      logic [31:0] pix;
      logic [1:0]  status;
      logic        div_live;
   } item_type;

   typedef struct packed {
      logic [63:0] num;
      logic [31:0] den;
      logic [31:0] rem;
      logic        neg;
   } div_type;

   typedef struct packed {
      logic [31:0] pix;
      logic        sat;
   } sat_type;

   // Clamps a 67-bit signed value to the 32-bit signed range.
   function automatic sat_type saturate(input logic [66:0] v);
      sat_type r;
      if (v[66:31] == {36{1'b0}} || v[66:31] == {36{1'b1}}) begin
         r.pix = v[31:0];
         r.sat = 1'b0;
      end else if (v[66]) begin
         r.pix = 32'h8000_0000;
         r.sat = 1'b1;
      end else begin
         r.pix = 32'h7FFF_FFFF;
         r.sat = 1'b1;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/pixel_pair_combiner_unit.sv
// ----------------------------------------------------------------------------
// pixel_pair_combiner_unit
// Combines one pixel of each of two images by a configured operation.
// ----------------------------------------------------------------------------
//   channel   ports   direction   handshake
//   request   req_*   in          req_valid / req_ready
//   result    rsp_*   out         rsp_valid / rsp_ready
//   control   csr_*   in          csr_we, no wait
//
// One request per cycle is taken while the result is not stalled; each result
// passes three arithmetic stages, sixteen divider stages of four quotient
// bits each, and two stages of floor correction, offset add and saturation.
// Every operation runs the full depth so results stay in order.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset clears the valid bits and the registers to operation 0, zero coefs.
module pixel_pair_combiner_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_pixel_first,
   input  logic signed [31:0] req_pixel_second,
   input  logic               req_first_blank,
   input  logic               req_second_blank,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pixel_out,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   ppc_pkg::cfg_type cfg_ff;
   logic             adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ppc_pkg::REG_OPERATION: cfg_ff.operation <= csr_wdata[2:0];
            ppc_pkg::REG_COEF_A1:   cfg_ff.a1 <= csr_wdata;
            ppc_pkg::REG_COEF_A2:   cfg_ff.a2 <= csr_wdata;
            ppc_pkg::REG_COEF_A3:   cfg_ff.a3 <= csr_wdata;
            default:                cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic              dv    [ppc_pkg::DIV_STAGES+1];
   ppc_pkg::item_type ditem [ppc_pkg::DIV_STAGES+1];
   ppc_pkg::div_type  ddiv  [ppc_pkg::DIV_STAGES+1];
   logic [31:0]       pix_out;

   ppc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .cfg          (cfg_ff),
      .in_valid     (req_valid),
      .pixel_first  (req_pixel_first),
      .pixel_second (req_pixel_second),
      .first_blank  (req_first_blank),
      .second_blank (req_second_blank),
      .out_valid    (dv[0]),
      .out_item     (ditem[0]),
      .out_div      (ddiv[0])
   );

   for (genvar g = 0; g < ppc_pkg::DIV_STAGES; g++) begin : g_div
      ppc_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv[g]),
         .in_item   (ditem[g]),
         .in_div    (ddiv[g]),
         .out_valid (dv[g+1]),
         .out_item  (ditem[g+1]),
         .out_div   (ddiv[g+1])
      );
   end

   ppc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .a2        (cfg_ff.a2),
      .in_valid  (dv[ppc_pkg::DIV_STAGES]),
      .in_item   (ditem[ppc_pkg::DIV_STAGES]),
      .in_div    (ddiv[ppc_pkg::DIV_STAGES]),
      .out_valid (rsp_valid),
      .pixel_out (pix_out),
      .status    (rsp_status)
   );

   assign rsp_pixel_out = $signed(pix_out);

   // Requests in flight, for checking only.
   logic [ppc_pkg::OCC_WIDTH-1:0] occ_ff, occ_in;

   always_comb begin
      occ_in = occ_ff;
      if (req_valid && req_ready) occ_in = occ_in + 1'b1;
      if (rsp_valid && rsp_ready) occ_in = occ_in - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= ppc_pkg::OCC_WIDTH'(ppc_pkg::PIPE_DEPTH))
      else $error("more requests in flight than pipeline stages");

   a_occ_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occ_ff != '0)
      else $error("result shown with no request in flight");

   a_zero_pix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ppc_pkg::STAT_BLANK || rsp_status == ppc_pkg::STAT_DIVZ)
      |-> rsp_pixel_out == '0)
      else $error("blank or divide by zero result not zero");

   a_sat_pix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ppc_pkg::STAT_SAT
      |-> pix_out == 32'h7FFF_FFFF || pix_out == 32'h8000_0000)
      else $error("saturated result not at a bound");

endmodule

// File: hw/rtl/ppc_front.sv
// ----------------------------------------------------------------------------
// ppc_front
// Three stages: coefficient products, partial products and sums, then
// rescaling and saturation of all operations but divide.
// ----------------------------------------------------------------------------
module ppc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  ppc_pkg::cfg_type    cfg,
   input  logic                in_valid,
   input  logic signed [31:0]  pixel_first,
   input  logic signed [31:0]  pixel_second,
   input  logic                first_blank,
   input  logic                second_blank,
   output logic                out_valid,
   output ppc_pkg::item_type   out_item,
   output ppc_pkg::div_type    out_div
);

   // Stage 1.
   logic               s1_v_ff;
   logic [2:0]         s1_op_ff, s1_op_in;
   logic [1:0]         s1_early_ff, s1_early_in;
   logic signed [63:0] s1_m1_ff, s1_m1_in;
   logic signed [63:0] s1_m2_ff, s1_m2_in;
   logic signed [31:0] s1_p2_ff, s1_p2_in;
   logic signed [31:0] p1z, p2z;

   always_comb begin
      s1_op_in = (cfg.operation > ppc_pkg::OP_DIV) ? ppc_pkg::OP_SUM : cfg.operation;
      p1z = pixel_first;
      p2z = pixel_second;
      s1_early_in = ppc_pkg::STAT_OK;
      if (s1_op_in == ppc_pkg::OP_SUM_ZERO) begin
         if (first_blank)  p1z = '0;
         if (second_blank) p2z = '0;
      end else if (first_blank || second_blank) begin
         s1_early_in = ppc_pkg::STAT_BLANK;
      end else if (s1_op_in == ppc_pkg::OP_DIV && pixel_second == '0) begin
         s1_early_in = ppc_pkg::STAT_DIVZ;
      end
      s1_m1_in = cfg.a1 * p1z;
      s1_m2_in = cfg.a2 * p2z;
      s1_p2_in = pixel_second;
   end

   // Stage 2.
   logic               s2_v_ff;
   logic [2:0]         s2_op_ff;
   logic [1:0]         s2_early_ff;
   logic signed [63:0] s2_ph_ff, s2_ph_in;
   logic signed [64:0] s2_pl_ff, s2_pl_in;
   logic [65:0]        s2_sum_ff, s2_sum_in;
   ppc_pkg::div_type   s2_div_ff, s2_div_in;
   logic [65:0]        a3_scaled;

   always_comb begin
      s2_ph_in = $signed(s1_m1_ff[63:32]) * s1_p2_ff;
      s2_pl_in = $signed({1'b0, s1_m1_ff[31:0]}) * s1_p2_ff;
      a3_scaled = (s1_op_ff == ppc_pkg::OP_SUM || s1_op_ff == ppc_pkg::OP_SUM_ZERO)
                  ? {{18{cfg.a3[31]}}, cfg.a3, 16'h0} : '0;
      s2_sum_in = {{2{s1_m1_ff[63]}}, s1_m1_ff} + {{2{s1_m2_ff[63]}}, s1_m2_ff} + a3_scaled;
      s2_div_in.num = s1_m1_ff[63] ? 64'(-s1_m1_ff) : s1_m1_ff;
      s2_div_in.den = s1_p2_ff[31] ? 32'(-s1_p2_ff) : s1_p2_ff;
      s2_div_in.rem = '0;
      s2_div_in.neg = s1_m1_ff[63] ^ s1_p2_ff[31];
   end

   // Stage 3.
   logic               s3_v_ff;
   ppc_pkg::item_type  s3_item_ff, s3_item_in;
   ppc_pkg::div_type   s3_div_ff;
   logic [96:0]        full;
   logic [66:0]        acc;
   ppc_pkg::sat_type   sat;

   always_comb begin
      full = {s2_ph_ff[63], s2_ph_ff, 32'h0} + {{32{s2_pl_ff[64]}}, s2_pl_ff}
           + {{33{cfg.a2[31]}}, cfg.a2, 32'h0};
      case (s2_op_ff)
         ppc_pkg::OP_MUL:  acc = {{2{full[96]}}, full[96:32]};
         ppc_pkg::OP_MEAN: acc = {{18{s2_sum_ff[65]}}, s2_sum_ff[65:17]};
         default:          acc = {{17{s2_sum_ff[65]}}, s2_sum_ff[65:16]};
      endcase
      sat = ppc_pkg::saturate(acc);
      s3_item_in.div_live = 1'b0;
      if (s2_early_ff != ppc_pkg::STAT_OK) begin
         s3_item_in.pix    = '0;
         s3_item_in.status = s2_early_ff;
      end else if (s2_op_ff == ppc_pkg::OP_DIV) begin
         s3_item_in.pix      = '0;
         s3_item_in.status   = ppc_pkg::STAT_OK;
         s3_item_in.div_live = 1'b1;
      end else begin
         s3_item_in.pix    = sat.pix;
         s3_item_in.status = sat.sat ? ppc_pkg::STAT_SAT : ppc_pkg::STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff    <= s1_op_in;
         s1_early_ff <= s1_early_in;
         s1_m1_ff    <= s1_m1_in;
         s1_m2_ff    <= s1_m2_in;
         s1_p2_ff    <= s1_p2_in;
         s2_op_ff    <= s1_op_ff;
         s2_early_ff <= s1_early_ff;
         s2_ph_ff    <= s2_ph_in;
         s2_pl_ff    <= s2_pl_in;
         s2_sum_ff   <= s2_sum_in;
         s2_div_ff   <= s2_div_in;
         s3_item_ff  <= s3_item_in;
         s3_div_ff   <= s2_div_ff;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_item  = s3_item_ff;
   assign out_div   = s3_div_ff;

endmodule

// File: hw/rtl/ppc_div_stage.sv
// ----------------------------------------------------------------------------
// ppc_div_stage
// One stage of the restoring divider: four quotient bits of magnitudes.
// ----------------------------------------------------------------------------
module ppc_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  ppc_pkg::item_type  in_item,
   input  ppc_pkg::div_type   in_div,
   output logic               out_valid,
   output ppc_pkg::item_type  out_item,
   output ppc_pkg::div_type   out_div
);

   logic              v_ff;
   ppc_pkg::item_type item_ff;
   ppc_pkg::div_type  div_ff, div_in;
   logic [32:0]       trial;

   // Quotient bits shift into the low end of num as the dividend leaves the top.
   always_comb begin
      div_in = in_div;
      trial  = '0;
      for (int i = 0; i < ppc_pkg::DIV_PER_STAGE; i++) begin
         trial      = {div_in.rem, div_in.num[63]};
         div_in.num = {div_in.num[62:0], 1'b0};
         if (trial >= {1'b0, div_in.den}) begin
            trial         = trial - {1'b0, div_in.den};
            div_in.num[0] = 1'b1;
         end
         div_in.rem = trial[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= in_item;
         div_ff  <= div_in;
      end
   end

   assign out_valid = v_ff;
   assign out_item  = item_ff;
   assign out_div   = div_ff;

endmodule

// File: hw/rtl/ppc_back.sv
// ----------------------------------------------------------------------------
// ppc_back
// Floor correction of the quotient, offset add and final saturation.
// ----------------------------------------------------------------------------
module ppc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic signed [31:0] a2,
   input  logic               in_valid,
   input  ppc_pkg::item_type  in_item,
   input  ppc_pkg::div_type   in_div,
   output logic               out_valid,
   output logic [31:0]        pixel_out,
   output logic [1:0]         status
);

   logic              b1_v_ff;
   ppc_pkg::item_type b1_item_ff;
   logic [65:0]       b1_q_ff, b1_q_in;
   logic              b2_v_ff;
   logic [31:0]       b2_pix_ff, b2_pix_in;
   logic [1:0]        b2_stat_ff, b2_stat_in;
   logic [66:0]       total;
   ppc_pkg::sat_type  sat;

   // For a negative quotient, -q - 1 is the complement of q.
   always_comb begin
      if (in_div.neg) begin
         b1_q_in = {2'b11, ~in_div.num} + {65'h0, (in_div.rem == '0)};
      end else begin
         b1_q_in = {2'b00, in_div.num};
      end
   end

   always_comb begin
      total = {b1_q_ff[65], b1_q_ff} + {{35{a2[31]}}, a2};
      sat   = ppc_pkg::saturate(total);
      if (b1_item_ff.div_live) begin
         b2_pix_in  = sat.pix;
         b2_stat_in = sat.sat ? ppc_pkg::STAT_SAT : ppc_pkg::STAT_OK;
      end else begin
         b2_pix_in  = b1_item_ff.pix;
         b2_stat_in = b1_item_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
      end else if (adv) begin
         b1_v_ff <= in_valid;
         b2_v_ff <= b1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_item_ff <= in_item;
         b1_q_ff    <= b1_q_in;
         b2_pix_ff  <= b2_pix_in;
         b2_stat_ff <= b2_stat_in;
      end
   end

   assign out_valid = b2_v_ff;
   assign pixel_out = b2_pix_ff;
   assign status    = b2_stat_ff;

endmodule

// File: tb/pixel_pair_combiner_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_pair_combiner_unit_tb
// Drives pixel pairs through the combiner under several operation and
// coefficient settings, predicts each combined pixel and status with exact
// wide arithmetic, and checks the results in order.
// ----------------------------------------------------------------------------
module pixel_pair_combiner_unit_tb;

   typedef struct packed {
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic               first_blank;
      logic               second_blank;
   } pair_type;

   typedef struct packed {
      logic signed [31:0] pix;
      logic [1:0]         status;
   } pixel_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_pixel_first = '0;
   logic signed [31:0] req_pixel_second = '0;
   logic               req_first_blank = 1'b0;
   logic               req_second_blank = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_pixel_out;
   logic [1:0]         rsp_status;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   pair_type         pending_pairs[$];
   pixel_result_type expected_pixels[$];
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   bit               hold_send = 1'b0;
   int               error_count = 0;
   logic [2:0]         cur_op = ppc_pkg::OP_SUM;
   logic signed [31:0] cur_a1 = '0, cur_a2 = '0, cur_a3 = '0;

   pixel_pair_combiner_unit u_top (.*);

   always #5 clock = ~clock;

   // Exact prediction of one combined pixel.
   function automatic pixel_result_type combine_pixels(pair_type p);
      pixel_result_type r;
      logic signed [191:0] p1, p2, acc, num, den, q;
      logic [2:0] op;
      op = (cur_op > ppc_pkg::OP_DIV) ? ppc_pkg::OP_SUM : cur_op;
      p1 = p.first;
      p2 = p.second;
      r.pix = '0;
      if (op == ppc_pkg::OP_SUM_ZERO) begin
         if (p.first_blank) p1 = 0;
         if (p.second_blank) p2 = 0;
      end else if (p.first_blank || p.second_blank) begin
         r.status = ppc_pkg::STAT_BLANK;
         return r;
      end
      case (op)
         ppc_pkg::OP_MEAN: acc = (cur_a1 * p1 + cur_a2 * p2) >>> (ppc_pkg::FRAC_BITS + 1);
         ppc_pkg::OP_MUL:  acc = (cur_a1 * p1 * p2
                                  + (192'(cur_a2) <<< (2 * ppc_pkg::FRAC_BITS)))
                                 >>> (2 * ppc_pkg::FRAC_BITS);
         ppc_pkg::OP_DIV: begin
            if (p2 == 0) begin
               r.status = ppc_pkg::STAT_DIVZ;
               return r;
            end
            num = cur_a1 * p1;
            den = p2;
            q = num / den;  // truncates toward zero; make it floor
            if ((q * den != num) && ((num < 0) != (den < 0))) q = q - 1;
            acc = q + cur_a2;
         end
         default: acc = (cur_a1 * p1 + cur_a2 * p2
                         + (192'(cur_a3) <<< ppc_pkg::FRAC_BITS)) >>> ppc_pkg::FRAC_BITS;
      endcase
      r.status = ppc_pkg::STAT_OK;
      if (acc > 192'sd2147483647) begin
         r.pix = 32'h7FFF_FFFF;
         r.status = ppc_pkg::STAT_SAT;
      end else if (acc < -192'sd2147483648) begin
         r.pix = 32'h8000_0000;
         r.status = ppc_pkg::STAT_SAT;
      end else begin
         r.pix = acc[31:0];
      end
      return r;
   endfunction

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_pixels.push_back(combine_pixels({req_pixel_first, req_pixel_second,
                                                      req_first_blank, req_second_blank}));
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
               pair_type p;
               p = pending_pairs.pop_front();
               req_valid <= 1'b1;
               req_pixel_first <= p.first;
               req_pixel_second <= p.second;
               req_first_blank <= p.first_blank;
               req_second_blank <= p.second_blank;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result pixel %h status %0d",
                        $time, rsp_pixel_out, rsp_status);
               error_count++;
            end else begin
               pixel_result_type e;
               e = expected_pixels.pop_front();
               if (rsp_pixel_out !== e.pix) begin
                  $display("%0t: pixel expected %h actual %h", $time, e.pix, rsp_pixel_out);
                  error_count++;
               end
               if (rsp_status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'(signed'($urandom_range(6 << 16)) - (3 << 16));
         3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
         4: return 32'($urandom_range(7)) - 32'd3;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_pair(logic [31:0] f, logic [31:0] s, bit fb, bit sb);
      pending_pairs.push_back({f, s, fb, sb});
   endtask

   task automatic wait_drained();
      while (pending_pairs.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ppc_pkg::REG_OPERATION: cur_op = val[2:0];
         ppc_pkg::REG_COEF_A1: cur_a1 = val;
         ppc_pkg::REG_COEF_A2: cur_a2 = val;
         default: cur_a3 = val;
      endcase
   endtask

   task automatic random_setting(int idx);
      logic [2:0] op;
      op = (idx < 8) ? 3'(idx) : 3'($urandom_range(ppc_pkg::OP_DIV));
      write_reg(ppc_pkg::REG_OPERATION, op);
      write_reg(ppc_pkg::REG_COEF_A1, (idx == 9) ? 32'h7FFF_FFFF
                : (idx == 10) ? 32'h8000_0000 : rand_word());
      write_reg(ppc_pkg::REG_COEF_A2, (idx == 9) ? 32'h8000_0000
                : (idx == 10) ? 32'h7FFF_FFFF : rand_word());
      write_reg(ppc_pkg::REG_COEF_A3, (idx == 9) ? 32'h7FFF_FFFF : rand_word());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: reset coefficients, then each operation with special cases.
      add_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
      add_pair(32'h0001_0000, 32'h0002_0000, 1'b1, 1'b0);
      wait_drained();
      write_reg(ppc_pkg::REG_COEF_A1, 32'h0001_0000);
      write_reg(ppc_pkg::REG_COEF_A2, 32'h0001_0000);
      write_reg(ppc_pkg::REG_COEF_A3, 32'h7FFF_FFFF);
      for (int op = ppc_pkg::OP_SUM; op <= 7; op++) begin
         write_reg(ppc_pkg::REG_OPERATION, 3'(op));
         add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
         add_pair(32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0);
         add_pair(32'hFFFF_FFFF, 32'h0000_0003, 1'b0, 1'b1);
         if (op == ppc_pkg::OP_DIV) add_pair(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
         wait_drained();
      end
      // Random phases with changing settings and idling profiles.
      for (int ph = 0; ph < 18; ph++) begin
         send_idle_pct = (ph < 6) ? 31 : (ph < 12) ? 60 : 0;
         recv_idle_pct = (ph < 6) ? 60 : (ph < 12) ? 31 : 0;
         random_setting(ph);
         for (int i = 0; i < 100; i++) begin
            bit fb, sb;
            fb = ($urandom_range(9) == 0);
            sb = ($urandom_range(9) == 0);
            add_pair(rand_word(), ($urandom_range(19) == 0) ? 32'h0 : rand_word(), fb, sb);
         end
         if (ph == 4) begin
            // Pause sending until the pipeline has emptied.
            while (pending_pairs.size() > 50) @(posedge clock);
            hold_send = 1'b1;
            while (req_valid || expected_pixels.size() > 0) @(posedge clock);
            hold_send = 1'b0;
         end
         wait_drained();
      end
      if (error_count == 0)
         $display("pixel_pair_combiner_unit_tb: clean");
      else
         $display("pixel_pair_combiner_unit_tb: errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("pixel_pair_combiner_unit_tb: errors");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_front.sv
hw/rtl/ppc_div_stage.sv
hw/rtl/ppc_back.sv
hw/rtl/pixel_pair_combiner_unit.sv
tb/pixel_pair_combiner_unit_tb.sv
